### rtl/core/sppq_pkg.sv
// Shared types, operation and status codes, and the type-to-priority map of the packet queue.
package sppq_pkg;

    localparam int DEF_QUEUE_DEPTH = 128;

    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_DEQ  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [2:0] TYPE_TELEMETRY = 3'd1;
    localparam logic [2:0] TYPE_IMAGE     = 3'd2;
    localparam logic [2:0] TYPE_VOICE     = 3'd3;
    localparam logic [2:0] TYPE_SCIENCE   = 3'd4;

    localparam logic [2:0] PRIO_WORST = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  ptype;
        logic [2:0]  prio;
        logic [31:0] tag;
    } t_entry;

    // Priority 1 is served first; unknown types land at the back.
    function automatic logic [2:0] prio_of(input logic [2:0] ptype);
        logic [2:0] p;
        case (ptype)
            TYPE_TELEMETRY: p = 3'd1;
            TYPE_VOICE:     p = 3'd2;
            TYPE_IMAGE:     p = 3'd3;
            TYPE_SCIENCE:   p = 3'd4;
            default:        p = PRIO_WORST;
        endcase
        return p;
    endfunction

endpackage

### rtl/core/stable_priority_packet_queue.sv
// Stable priority packet queue: sorted insertion into one entry memory kept as a ring.
//
// A command is taken at a clock edge where start is high and busy is low.
// i_func selects enqueue, dequeue or peek (the unused code behaves as a peek).
// Each command yields exactly one result, shown for one cycle with o_valid high;
// the receiver must take it then, since the block cannot hold a result back.
// Entries live in one memory with a registered read, addressed as a ring from a
// head pointer, so a dequeue only moves the head.
// Busy stays low for an enqueue into an empty or a full queue and for a dequeue
// or peek of an empty queue. A dequeue or peek of a non-empty queue raises busy
// while the head entry is read. An enqueue that moves entries back raises busy
// for the insertion walk from the tail; one memory entry is read and one written
// each cycle, and the last step writes the new entry.
// A new command may be given in the cycle that its predecessor's result is shown.
// Reset empties the queue and sets the next id to one; no clearing pass is needed.
module stable_priority_packet_queue #(
    parameter int QUEUE_DEPTH = sppq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [2:0]  i_packet_type,
    input  logic [31:0] i_payload_tag,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_packet_id,
    output logic [2:0]  o_out_type,
    output logic [2:0]  o_out_priority,
    output logic [31:0] o_out_tag,
    output logic [7:0]  o_occupancy
);
    import sppq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_SHIFT,
        S_PLACE
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_next_id, n_next_id;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_pos, n_pos;
    logic [1:0]    r_func, n_func;
    t_entry        r_new, n_new;
    t_entry        r_rd;

    logic          n_valid;
    logic [1:0]    n_status;
    t_entry        n_res;
    logic [7:0]    n_occ;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_entry        mem_wd;
    logic [AW-1:0] mem_ra;

    t_entry mem [QUEUE_DEPTH];

    // Logical position in the queue to memory address, wrapping past the end of the ring.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, l};
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [7:0] occ8(input logic [CW-1:0] c);
        logic [CW+7:0] w;
        w = {8'b0, c};
        return w[7:0];
    endfunction

    assign busy = (r_state != S_IDLE);

    always_comb begin
        t_entry ent;
        ent       = '{id: r_next_id, ptype: i_packet_type, prio: prio_of(i_packet_type),
                      tag: i_payload_tag};
        n_state   = r_state;
        n_count   = r_count;
        n_next_id = r_next_id;
        n_head    = r_head;
        n_pos     = r_pos;
        n_func    = r_func;
        n_new     = r_new;
        n_valid   = 1'b0;
        n_status  = ST_DONE;
        n_res     = r_new;
        n_occ     = occ8(r_count);
        mem_we    = 1'b0;
        mem_wa    = r_head;
        mem_wd    = r_new;
        mem_ra    = r_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_new  = ent;
                    n_func = i_func;
                    if (i_func == FUNC_ENQ) begin
                        n_next_id = r_next_id + 32'd1;
                        if (r_count == DEPTH_C) begin
                            n_valid  = 1'b1;
                            n_status = ST_FULL;
                            n_res    = ent;
                        end else if (r_count == '0) begin
                            mem_we   = 1'b1;
                            mem_wa   = r_head;
                            mem_wd   = ent;
                            n_count  = CW'(1);
                            n_valid  = 1'b1;
                            n_res    = ent;
                            n_occ    = occ8(CW'(1));
                        end else begin
                            // The walk starts at the tail; the entry there arrives next cycle.
                            mem_ra  = phys(r_head, r_count[AW-1:0] - AW'(1));
                            n_pos   = r_count[AW-1:0];
                            n_state = S_SHIFT;
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_EMPTY;
                        n_res    = '{id: 32'd0, ptype: TYPE_TELEMETRY, prio: 3'd0, tag: 32'd0};
                    end else begin
                        mem_ra  = r_head;
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_valid = 1'b1;
                n_res   = r_rd;
                if (r_func == FUNC_DEQ) begin
                    n_count = r_count - CW'(1);
                    n_head  = (r_head == LAST_A) ? '0 : r_head + AW'(1);
                    n_occ   = occ8(r_count - CW'(1));
                end
                n_state = S_IDLE;
            end
            S_SHIFT: begin
                // Write position and the next read address differ by two, so they never collide.
                mem_we = 1'b1;
                mem_wa = phys(r_head, r_pos);
                if (r_rd.prio > r_new.prio) begin
                    mem_wd = r_rd;
                    n_pos  = r_pos - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_ra = phys(r_head, r_pos - AW'(2));
                    end
                end else begin
                    mem_wd  = r_new;
                    n_count = r_count + CW'(1);
                    n_valid = 1'b1;
                    n_occ   = occ8(r_count + CW'(1));
                    n_state = S_IDLE;
                end
            end
            S_PLACE: begin
                mem_we  = 1'b1;
                mem_wa  = r_head;
                mem_wd  = r_new;
                n_count = r_count + CW'(1);
                n_valid = 1'b1;
                n_occ   = occ8(r_count + CW'(1));
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= 32'd1;
            r_head    <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_head    <= n_head;
            o_valid   <= n_valid;
        end
        r_pos          <= n_pos;
        r_func         <= n_func;
        r_new          <= n_new;
        o_status       <= n_status;
        o_packet_id    <= n_res.id;
        o_out_type     <= n_res.ptype;
        o_out_priority <= n_res.prio;
        o_out_tag      <= n_res.tag;
        o_occupancy    <= n_occ;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count exceeds depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted transaction produced neither a result nor busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_count == DEPTH_C))
        else $error("full status reported on a queue that is not full");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_pos != '0))
        else $error("insertion walk reached the head without stopping");
`endif

endmodule
